### rtl/hsv_pkg.sv
// Shared types and constants for the HSV to RGB565 color converter.
`default_nettype none

package hsv_pkg;

    // Fixed-point 1.0 for saturation and brightness (UQ1.12)
    localparam logic [12:0] ONE_Q12  = 13'd4096;
    // Fixed-point 1.0 for the p, q, t terms before scaling by v (UQ1.28)
    localparam logic [28:0] ONE_Q28  = 29'h1000_0000;
    // One full turn of the hue fraction (UQ1.16)
    localparam logic [16:0] ONE_Q16  = 17'h1_0000;
    // Rounding offset for the final shift by 40
    localparam logic [48:0] HALF_Q40 = 49'h0_0080_0000_0000;

    // Channel lanes inside the packed arrays
    localparam int CH_R = 0;
    localparam int CH_G = 1;
    localparam int CH_B = 2;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

    typedef struct packed {
        sector_t      sector;
        logic [15:0]  frac;
        logic [12:0]  sat;
        logic [12:0]  val;
    } sec_word_t;

    typedef struct packed {
        logic [12:0]       val;
        logic [2:0][28:0]  term;
    } term_word_t;

    typedef struct packed {
        logic [2:0][40:0]  prod;
    } prod_word_t;

    typedef struct packed {
        logic [2:0][7:0]   chan;
    } pix_word_t;

endpackage

`default_nettype wire

### rtl/hsv_sector.sv
// Stage 1: clamp saturation and brightness, split hue into sector and fraction.
`default_nettype none

module hsv_sector
    import hsv_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] hue,
    input  wire logic [12:0] saturation,
    input  wire logic [12:0] brightness,
    output logic             out_valid,
    input  wire logic        out_ready,
    output sec_word_t        out_word
);

    logic        valid_reg;
    sec_word_t   word_reg;
    sec_word_t   word_next;
    logic [18:0] hue6;

    // hue * 6 as (hue << 2) + (hue << 1)
    assign hue6 = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};

    always_comb begin
        word_next.sector = sector_t'(hue6[18:16]);
        word_next.frac   = hue6[15:0];
        word_next.sat    = (saturation > ONE_Q12) ? ONE_Q12 : saturation;
        word_next.val    = (brightness > ONE_Q12) ? ONE_Q12 : brightness;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire

### rtl/hsv_terms.sv
// Stage 2: form the p, q, t terms and route them to the channels by sector.
`default_nettype none

module hsv_terms
    import hsv_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire sec_word_t in_word,
    output logic           out_valid,
    input  wire logic      out_ready,
    output term_word_t     out_word
);

    logic        valid_reg;
    term_word_t  word_reg;
    term_word_t  word_next;
    logic [16:0] frac_inv;
    logic [28:0] sf;
    logic [29:0] sf_inv;
    logic [28:0] term_p;
    logic [28:0] term_q;
    logic [28:0] term_t;

    assign frac_inv = ONE_Q16 - {1'b0, in_word.frac};
    assign sf       = 29'({16'd0, in_word.sat} * {13'd0, in_word.frac});
    assign sf_inv   = 30'({17'd0, in_word.sat} * {13'd0, frac_inv});

    assign term_p = {ONE_Q12 - in_word.sat, 16'h0000};
    assign term_q = ONE_Q28 - sf;
    assign term_t = 29'({1'b0, ONE_Q28} - sf_inv);

    always_comb begin
        word_next.val = in_word.val;
        unique case (in_word.sector)
            SEC_RED_YEL: begin
                word_next.term[CH_R] = ONE_Q28;
                word_next.term[CH_G] = term_t;
                word_next.term[CH_B] = term_p;
            end
            SEC_YEL_GRN: begin
                word_next.term[CH_R] = term_q;
                word_next.term[CH_G] = ONE_Q28;
                word_next.term[CH_B] = term_p;
            end
            SEC_GRN_CYN: begin
                word_next.term[CH_R] = term_p;
                word_next.term[CH_G] = ONE_Q28;
                word_next.term[CH_B] = term_t;
            end
            SEC_CYN_BLU: begin
                word_next.term[CH_R] = term_p;
                word_next.term[CH_G] = term_q;
                word_next.term[CH_B] = ONE_Q28;
            end
            SEC_BLU_MAG: begin
                word_next.term[CH_R] = term_t;
                word_next.term[CH_G] = term_p;
                word_next.term[CH_B] = ONE_Q28;
            end
            default: begin
                word_next.term[CH_R] = ONE_Q28;
                word_next.term[CH_G] = term_p;
                word_next.term[CH_B] = term_q;
            end
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire

### rtl/hsv_mul.sv
// Stage 3: scale each channel term by the brightness.
`default_nettype none

module hsv_mul
    import hsv_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire term_word_t in_word,
    output logic            out_valid,
    input  wire logic       out_ready,
    output prod_word_t      out_word
);

    logic       valid_reg;
    prod_word_t word_reg;
    prod_word_t word_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            word_next.prod[i] = 41'({29'd0, in_word.val} * {13'd0, in_word.term[i]});
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire

### rtl/hsv_round.sv
// Stage 4: multiply by 255, round half up and keep the 8-bit channel.
`default_nettype none

module hsv_round
    import hsv_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire prod_word_t in_word,
    output logic            out_valid,
    input  wire logic       out_ready,
    output pix_word_t       out_word
);

    logic             valid_reg;
    pix_word_t        word_reg;
    pix_word_t        word_next;
    logic [2:0][48:0] scaled;

    // x * 255 as (x << 8) - x
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            scaled[i] = {in_word.prod[i], 8'h00} - {8'h00, in_word.prod[i]} + HALF_Q40;
            word_next.chan[i] = scaled[i][47:40];
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire

### rtl/hsv_to_rgb565.sv
// HSV to RGB888/RGB565 converter: top level with the four-stage pipeline.
//
// Input stream (s_*): one word per color, hue as a fraction of a turn
// (65536 = one turn), saturation and brightness in UQ1.12 (4096 = 1.0;
// larger values clamp to 1.0).
// Output stream (m_*): 8-bit red, green and blue, each channel term *
// brightness * 255 rounded half up, plus the RGB565 pack of their top bits.
// A word passes the register stages in order: sector split, term forming,
// brightness multiply, and scale-and-round, one register stage each.
// Throughput is one word per clock while m_tready stays high; the
// multiplies are split so that no stage holds more than one multiplier
// deep of logic.
// Each stage has its own valid bit and takes a new word when it is empty
// or its successor takes its word, so bubbles close up while the output
// is stalled. With m_tready low the output word holds and the pipeline
// keeps filling until all four stages are full, then s_tready drops.
// Reset (aresetn low, synchronous) empties all stages; no word is in flight
// afterwards.
`default_nettype none

module hsv_to_rgb565
    import hsv_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // hue[15:0], saturation[28:16], brightness[41:29], zeros
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // red[7:0], green[15:8], blue[23:16], packed_565[39:24]
);

    logic       sec_valid;
    logic       sec_ready;
    sec_word_t  sec_word;
    logic       term_valid;
    logic       term_ready;
    term_word_t term_word;
    logic       prod_valid;
    logic       prod_ready;
    prod_word_t prod_word;
    pix_word_t  pix_word;
    logic [15:0] pack;

    hsv_sector u_sector (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .hue        (s_tdata[15:0]),
        .saturation (s_tdata[28:16]),
        .brightness (s_tdata[41:29]),
        .out_valid  (sec_valid),
        .out_ready  (sec_ready),
        .out_word   (sec_word)
    );

    hsv_terms u_terms (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sec_valid),
        .in_ready  (sec_ready),
        .in_word   (sec_word),
        .out_valid (term_valid),
        .out_ready (term_ready),
        .out_word  (term_word)
    );

    hsv_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (term_valid),
        .in_ready  (term_ready),
        .in_word   (term_word),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_word  (prod_word)
    );

    hsv_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_word   (prod_word),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (pix_word)
    );

    assign pack = {pix_word.chan[CH_R][7:3], pix_word.chan[CH_G][7:2], pix_word.chan[CH_B][7:3]};

    assign m_tdata = {pack, pix_word.chan[CH_B], pix_word.chan[CH_G], pix_word.chan[CH_R]};

`ifndef ASSERT_OFF
    // An empty or draining output stage must let the input side accept
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("s_tready low while the output stage can advance");

    // A word accepted with the receiver ready throughout must reach the output
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && m_tready) ##1 m_tready ##1 m_tready ##1 m_tready
        |=> m_tvalid)
        else $error("accepted word did not reach the output in four cycles");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire
